@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge, muted while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Condition that must never be true on a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");

`endif

@@ rtl/core/ieu_pkg.sv @@
`timescale 1ns / 1ps

package ieu_pkg;

	localparam int DATA_W        = 64;
	localparam int FRAC_BITS_DEF = 32;

	localparam logic [DATA_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} ieu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WAIT,
		ST_JOIN,
		ST_SUM
	} ieu_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_FIN
	} ieu_md_state_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} ieu_md_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic clamp;
	} ieu_md_rsp_t;

endpackage

@@ rtl/core/ieu_muldiv.sv @@
`timescale 1ns / 1ps

// Sign-magnitude fixed point multiply / divide, one bit per cycle on a shared
// 66-bit add/subtract unit. Multiply: shift-add. Divide: restoring division.
module ieu_muldiv import ieu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ieu_md_req_t              req,
	input  logic signed [DATA_W-1:0] term,
	input  logic signed [DATA_W-1:0] operand,
	output ieu_md_rsp_t              rsp,
	output logic signed [DATA_W-1:0] product
);

	localparam int NUM_W  = DATA_W + FRAC_BITS;
	localparam int FULL_W = 2 * DATA_W;
	localparam int CNT_W  = $clog2(NUM_W + 1);

	ieu_md_state_t state_q, state_nx;
	logic [CNT_W-1:0]  cnt_q;
	logic              is_div_q;
	logic              neg_q;
	logic [DATA_W-1:0] acc_q;
	logic [FULL_W-1:0] sh_q;
	logic [DATA_W-1:0] opd_q;

	logic [DATA_W-1:0] a_mag, b_mag;
	logic [DATA_W+1:0] sum_a, sum_b, sum_y;
	logic              q_bit;
	logic [DATA_W-1:0] acc_nx;
	logic [FULL_W-1:0] sh_nx;
	logic [FULL_W-1:0] full;
	logic [DATA_W-1:0] limit, mag;
	logic              ovf;

	assign a_mag = term[DATA_W-1] ? (DATA_W'(0) - $unsigned(term)) : $unsigned(term);
	assign b_mag = operand[DATA_W-1] ? (DATA_W'(0) - $unsigned(operand)) : $unsigned(operand);

	// shared add/subtract unit
	always_comb begin
		if (is_div_q) begin
			sum_a = {1'b0, acc_q, sh_q[NUM_W-1]};
			sum_b = {2'b00, opd_q};
			sum_y = sum_a - sum_b;
		end else begin
			sum_a = {2'b00, acc_q};
			sum_b = sh_q[0] ? {2'b00, opd_q} : '0;
			sum_y = sum_a + sum_b;
		end
	end

	always_comb begin
		q_bit = ~sum_y[DATA_W+1];
		if (is_div_q) begin
			acc_nx = q_bit ? sum_y[DATA_W-1:0] : sum_a[DATA_W-1:0];
			sh_nx  = {sh_q[FULL_W-2:0], q_bit};
		end else begin
			acc_nx = sum_y[DATA_W:1];
			sh_nx  = {{DATA_W{1'b0}}, sum_y[0], sh_q[DATA_W-1:1]};
		end
	end

	// truncate to FRAC_BITS fraction bits, then clamp the magnitude and sign it
	always_comb begin
		if (is_div_q)
			full = FULL_W'(sh_q[NUM_W-1:0]);
		else
			full = {acc_q, sh_q[DATA_W-1:0]} >> FRAC_BITS;
		limit   = neg_q ? SAT_MIN : SAT_MAX;
		ovf     = (full[FULL_W-1:DATA_W] != '0) || (full[DATA_W-1:0] > limit);
		mag     = ovf ? limit : full[DATA_W-1:0];
		product = neg_q ? $signed(DATA_W'(0) - mag) : $signed(mag);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			MD_IDLE: begin
				if (req.start)
					state_nx = MD_RUN;
			end
			MD_RUN: begin
				if (cnt_q == CNT_W'(1))
					state_nx = MD_FIN;
			end
			MD_FIN:  state_nx = MD_IDLE;
			default: state_nx = MD_IDLE;
		endcase
	end

	always_comb begin
		rsp.busy  = (state_q != MD_IDLE);
		rsp.done  = (state_q == MD_FIN);
		rsp.clamp = (state_q == MD_FIN) && ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == MD_IDLE && req.start)
				cnt_q <= req.is_div ? CNT_W'(NUM_W) : CNT_W'(DATA_W);
			else if (state_q == MD_RUN)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MD_IDLE && req.start) begin
			is_div_q <= req.is_div;
			neg_q    <= term[DATA_W-1] ^ operand[DATA_W-1];
			acc_q    <= '0;
			if (req.is_div) begin
				sh_q  <= FULL_W'(a_mag) << FRAC_BITS;
				opd_q <= b_mag;
			end else begin
				sh_q  <= FULL_W'(b_mag);
				opd_q <= a_mag;
			end
		end else if (state_q == MD_RUN) begin
			acc_q <= acc_nx;
			sh_q  <= sh_nx;
		end
	end

endmodule

@@ rtl/core/infix_expression_evaluator_unit.sv @@
`timescale 1ns / 1ps

// Evaluates an infix expression of + - * / over signed fixed point with FRAC_BITS
// fraction bits, one operand per transfer, each tagged with the operator that follows
// it; the transfer with last set closes the expression and yields one result.
// One operand at a time: in_ready is low while it is processed. An operand that only
// starts or ends a term passes through LOAD and JOIN, and SUM if it ends one; one
// that multiplies the term or divides it by a nonzero value waits for the bit-serial
// multiply/divide unit (one quotient or partial-product bit per cycle). A new
// expression may start while the previous result still waits at the output register.
`include "assert_macros.svh"

module infix_expression_evaluator_unit import ieu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] value,
	input  logic [1:0]               operation,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] result,
	output logic                     error_code,
	output logic                     saturated
);

	ieu_state_t state_q, state_nx;

	logic signed [DATA_W-1:0] v_q;
	ieu_op_t                  op_q;
	logic                     last_q;

	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] term_q;
	logic              neg_q;
	ieu_op_t           join_q;
	logic              zd_q;
	logic              clamp_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] result_q;
	logic                     err_q;
	logic                     sat_q;

	ieu_md_req_t              md_req;
	ieu_md_rsp_t              md_rsp;
	logic signed [DATA_W-1:0] md_product;

	logic              div_zero;
	logic              term_ends;
	logic              out_free;
	logic              sum_go;
	logic [DATA_W-1:0] add_r;
	logic              sa, sb, same_sign, sum_ovf;
	logic [DATA_W-1:0] sum_new;

	ieu_muldiv #(
		.FRAC_BITS(FRAC_BITS)
	) u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (md_req),
		.term    ($signed(term_q)),
		.operand (v_q),
		.rsp     (md_rsp),
		.product (md_product)
	);

	// saturating add/subtract of the finished term into the running sum
	always_comb begin
		add_r     = neg_q ? (sum_q - term_q) : (sum_q + term_q);
		sa        = sum_q[DATA_W-1];
		sb        = term_q[DATA_W-1];
		same_sign = neg_q ? (sa != sb) : (sa == sb);
		sum_ovf   = same_sign && (add_r[DATA_W-1] != sa);
		sum_new   = sum_ovf ? (sa ? SAT_MIN : SAT_MAX) : add_r;
	end

	always_comb begin
		div_zero  = (join_q == OP_DIV) && (v_q == '0);
		term_ends = last_q || (op_q == OP_ADD) || (op_q == OP_SUB);
		out_free  = !out_valid_q || out_ready;
		sum_go    = !last_q || out_free;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nx = ST_LOAD;
			end
			ST_LOAD: state_nx = md_req.start ? ST_WAIT : ST_JOIN;
			ST_WAIT: begin
				if (md_rsp.done)
					state_nx = ST_JOIN;
			end
			ST_JOIN: state_nx = term_ends ? ST_SUM : ST_IDLE;
			ST_SUM: begin
				if (sum_go)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		md_req.start  = (state_q == ST_LOAD) &&
			((join_q == OP_MUL) || ((join_q == OP_DIV) && !div_zero));
		md_req.is_div = (join_q == OP_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			term_q      <= '0;
			neg_q       <= 1'b0;
			join_q      <= OP_ADD;
			zd_q        <= 1'b0;
			clamp_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SUM && last_q && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (div_zero) begin
						zd_q   <= 1'b1;
						term_q <= '0;
					end else if (join_q != OP_MUL && join_q != OP_DIV) begin
						term_q <= $unsigned(v_q);
					end
				end
				ST_WAIT: begin
					if (md_rsp.done) begin
						term_q  <= $unsigned(md_product);
						clamp_q <= clamp_q | md_rsp.clamp;
					end
				end
				ST_JOIN: begin
					if (!term_ends)
						join_q <= op_q;
				end
				ST_SUM: begin
					if (sum_go) begin
						if (last_q) begin
							sum_q       <= '0;
							term_q      <= '0;
							neg_q       <= 1'b0;
							join_q      <= OP_ADD;
							zd_q        <= 1'b0;
							clamp_q     <= 1'b0;
						end else begin
							sum_q   <= sum_new;
							clamp_q <= clamp_q | sum_ovf;
							neg_q   <= (op_q == OP_SUB);
							join_q  <= OP_ADD;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			v_q    <= value;
			op_q   <= ieu_op_t'(operation);
			last_q <= last;
		end
		if (state_q == ST_SUM && last_q && out_free) begin
			result_q <= zd_q ? '0 : $signed(sum_new);
			err_q    <= zd_q;
			sat_q    <= clamp_q | sum_ovf;
		end
	end

	assign out_valid  = out_valid_q;
	assign result     = result_q;
	assign error_code = err_q;
	assign saturated  = sat_q;

	`ASSERT_CLK(a_ready_unit_idle, clk, arst_n, in_ready |-> !md_rsp.busy)
	`ASSERT_NEVER(a_done_outside_wait, clk, arst_n, md_rsp.done && state_q != ST_WAIT)
	`ASSERT_CLK(a_start_takes, clk, arst_n, md_req.start |=> md_rsp.busy)
	`ASSERT_CLK(a_hold_on_stall, clk, arst_n, (state_q == ST_SUM && last_q && out_valid && !out_ready) |=> (state_q == ST_SUM))

endmodule
